[rtl/core/ppabr_pkg.sv]
`timescale 1ns / 1ps

package ppabr_pkg;

	// fixed field widths of the channels
	localparam int OP_W       = 3;
	localparam int CNT_W      = 7;
	localparam int WA_W       = 12;
	localparam int FRAME_W    = 32;
	localparam int SIZE_W     = 13;
	localparam int CFG_ADDR_W = 2;
	localparam int KIND_W     = 2;

	// parameter defaults
	localparam int STORE_FRAMES_DEF = 4096;
	localparam int FRAME_BITS_DEF   = 32;
	localparam int MAX_REQUEST_DEF  = 64;

	// buffer_frames after reset
	localparam int SIZE_RESET = 4096;

	typedef enum logic [OP_W-1:0] {
		OP_READ   = 3'd0,
		OP_WRITE  = 3'd1,
		OP_FILL   = 3'd2,
		OP_PLAY   = 3'd3,
		OP_STOP   = 3'd4,
		OP_PAUSE  = 3'd5,
		OP_RESUME = 3'd6
	} op_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_STORED  = 2'd0,
		KIND_SILENCE = 2'd1,
		KIND_ACK     = 2'd2
	} kind_t;

	typedef enum logic [CFG_ADDR_W-1:0] {
		CFG_STATIC_MODE   = 2'd0,
		CFG_LOOP_ENABLE   = 2'd1,
		CFG_BUFFER_FRAMES = 2'd2
	} cfg_idx_t;

	// configuration as seen by the sequencer, size already saturated
	typedef struct packed {
		logic              static_mode;
		logic              loop_enable;
		logic [SIZE_W-1:0] size;
		logic [SIZE_W-1:0] sub;
	} cfg_t;

	// one result handed from the sequencer to the output stage
	typedef struct packed {
		kind_t            kind;
		logic [CNT_W-1:0] count;
		logic             playing;
		logic             last;
	} issue_t;

	// largest k with frames << k still below the write address range
	function automatic int wmod_shift(input int frames);
		int k;
		k = 0;
		for (int i = 1; i < WA_W; i++) begin
			if ((frames << i) < (1 << WA_W))
				k = i;
		end
		return k;
	endfunction

endpackage

[rtl/core/ppabr_ifs.sv]
`timescale 1ns / 1ps

interface ppabr_item_if;
	logic                           valid;
	logic                           ready;
	logic [ppabr_pkg::OP_W-1:0]     operation;
	logic [ppabr_pkg::CNT_W-1:0]    request_frames;
	logic [ppabr_pkg::WA_W-1:0]     write_address;
	logic [ppabr_pkg::FRAME_W-1:0]  write_frame;
	logic                           half_select;

	modport source (
		output valid, operation, request_frames, write_address, write_frame, half_select,
		input  ready
	);
	modport sink (
		input  valid, operation, request_frames, write_address, write_frame, half_select,
		output ready
	);
endinterface

interface ppabr_result_if;
	logic                           valid;
	logic                           ready;
	logic [ppabr_pkg::FRAME_W-1:0]  frame_value;
	logic [ppabr_pkg::KIND_W-1:0]   result_kind;
	logic [ppabr_pkg::CNT_W-1:0]    frames_counted;
	logic                           is_playing;
	logic                           last_result;

	modport source (
		output valid, frame_value, result_kind, frames_counted, is_playing, last_result,
		input  ready
	);
	modport sink (
		input  valid, frame_value, result_kind, frames_counted, is_playing, last_result,
		output ready
	);
endinterface

interface ppabr_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [ppabr_pkg::CFG_ADDR_W-1:0]  addr;
	logic [ppabr_pkg::SIZE_W-1:0]      wdata;

	modport source (
		output valid, addr, wdata,
		input  ready
	);
	modport sink (
		input  valid, addr, wdata,
		output ready
	);
endinterface

[rtl/core/ppabr_frame_mem.sv]
`timescale 1ns / 1ps

module ppabr_frame_mem #(
	parameter int DEPTH = ppabr_pkg::STORE_FRAMES_DEF,
	parameter int WIDTH = ppabr_pkg::FRAME_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			store_q[waddr] <= wdata;
	end

	// read data holds while no read is issued
	always_ff @(posedge clk) begin
		if (re)
			rdata_q <= store_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/ppabr_out_stage.sv]
`timescale 1ns / 1ps

module ppabr_out_stage #(
	parameter int FRAME_BITS = ppabr_pkg::FRAME_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  issue_valid,
	input  ppabr_pkg::issue_t     issue,
	output logic                  can_issue,
	input  logic [FRAME_BITS-1:0] rd_data,
	ppabr_result_if.source        results
);

	logic                          iss_v_s1;
	ppabr_pkg::issue_t             iss_s1;
	logic                          res_v_q;
	ppabr_pkg::issue_t             res_info_q;
	logic [ppabr_pkg::FRAME_W-1:0] res_frame_q;
	logic                          adv;

	assign adv       = iss_v_s1 && (!res_v_q || results.ready);
	assign can_issue = !iss_v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_v_s1 <= 1'b0;
			res_v_q  <= 1'b0;
		end else begin
			if (can_issue)
				iss_v_s1 <= issue_valid;
			if (adv)
				res_v_q <= 1'b1;
			else if (results.ready)
				res_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (can_issue && issue_valid)
			iss_s1 <= issue;
		if (adv) begin
			res_info_q  <= iss_s1;
			res_frame_q <= (iss_s1.kind == ppabr_pkg::KIND_STORED) ?
				ppabr_pkg::FRAME_W'(rd_data) : '0;
		end
	end

	assign results.valid          = res_v_q;
	assign results.frame_value    = res_frame_q;
	assign results.result_kind    = res_info_q.kind;
	assign results.frames_counted = res_info_q.count;
	assign results.is_playing     = res_info_q.playing;
	assign results.last_result    = res_info_q.last;

	// memory data must not move under a stalled stored frame
	a_rd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		iss_v_s1 && !adv |=> $stable(rd_data))
		else $error("frame data changed under a stalled result");

endmodule

[rtl/core/ppabr_read_seq.sv]
`timescale 1ns / 1ps

module ppabr_read_seq #(
	parameter int STORE_FRAMES = ppabr_pkg::STORE_FRAMES_DEF,
	parameter int FRAME_BITS   = ppabr_pkg::FRAME_BITS_DEF,
	parameter int MAX_REQUEST  = ppabr_pkg::MAX_REQUEST_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	ppabr_item_if.sink                      items,
	input  ppabr_pkg::cfg_t                 cfg_regs,
	input  logic                            can_issue,
	output logic                            issue_valid,
	output ppabr_pkg::issue_t               issue,
	output logic                            mem_we,
	output logic [$clog2(STORE_FRAMES)-1:0] mem_waddr,
	output logic [FRAME_BITS-1:0]           mem_wdata,
	output logic                            mem_re,
	output logic [$clog2(STORE_FRAMES)-1:0] mem_raddr
);

	localparam int ADDR_W    = $clog2(STORE_FRAMES);
	localparam int SIZE_TOP  = (1 << ppabr_pkg::SIZE_W) - 1;
	localparam int SIZE_MAX  = (STORE_FRAMES < SIZE_TOP) ? STORE_FRAMES : SIZE_TOP;
	localparam int CUR_W     = $clog2(SIZE_MAX);
	localparam int CNT_W     = ppabr_pkg::CNT_W;
	localparam int WA_W      = ppabr_pkg::WA_W;
	localparam int SIZE_W    = ppabr_pkg::SIZE_W;
	localparam int EXT_W     = SIZE_W + 1;
	localparam int D_W       = SIZE_W + 3;
	localparam bit WMOD_NEED = STORE_FRAMES < (1 << WA_W);
	localparam int WMOD_TOP  = ppabr_pkg::wmod_shift(STORE_FRAMES);
	localparam int STEP_W    = $clog2(WA_W);

	typedef enum logic [2:0] {
		S_IDLE,
		S_WMOD,
		S_SEG,
		S_FRAME,
		S_SIL,
		S_ACK
	} state_t;

	state_t                  state_q;
	logic [CUR_W-1:0]        cursor_q;
	logic [1:0]              consumed_q;
	logic                    playing_q;
	logic                    paused_q;
	logic                    idx_q;
	logic [1:0]              local_q;
	logic [CNT_W-1:0]        n_q;
	logic [CNT_W-1:0]        left_q;
	logic [CNT_W-1:0]        got_q;
	logic [CNT_W-1:0]        emitted_q;
	logic [SIZE_W-1:0]       avail_q;
	logic                    inf_q;
	logic [ADDR_W-1:0]       addr_q;
	logic                    play_out_q;
	logic [WA_W-1:0]         wa_q;
	logic [STEP_W-1:0]       step_q;
	logic [FRAME_BITS-1:0]   wframe_q;

	logic                    accept;
	logic                    now_play;
	logic [CNT_W-1:0]        n_sat;
	logic [EXT_W-1:0]        cur_ext;
	logic [EXT_W-1:0]        size_ext;
	logic [EXT_W-1:0]        sub_ext;
	logic                    cursor_hi;
	logic                    cursor_idx;
	logic [D_W-1:0]          seg_d;
	logic                    seg_inf;
	logic                    seg_zero;
	logic                    seg_fit;
	logic                    seg_brk;
	logic [CUR_W-1:0]        cursor_nxt;
	logic [ADDR_W-1:0]       addr_nxt;
	logic                    is_last;
	logic                    half_end;
	logic                    more_sil;
	logic [31:0]             wmod_div;
	logic [WA_W-1:0]         wa_red;

	assign items.ready = (state_q == S_IDLE);
	assign accept      = items.valid && items.ready;
	assign now_play    = playing_q && !paused_q;

	assign n_sat = (items.request_frames > CNT_W'(MAX_REQUEST)) ?
		CNT_W'(MAX_REQUEST) : items.request_frames;

	assign cur_ext    = EXT_W'(cursor_q);
	assign size_ext   = EXT_W'(cfg_regs.size);
	assign sub_ext    = EXT_W'(cfg_regs.sub);
	// cursor past the second half: read answers with a bare acknowledgement
	assign cursor_hi  = cur_ext >= {sub_ext[EXT_W-2:0], 1'b0};
	assign cursor_idx = cur_ext >= sub_ext;

	// frames left in the current segment; negative means unbounded
	always_comb begin
		if (cfg_regs.static_mode)
			seg_d = D_W'(cfg_regs.size) - D_W'(cursor_q);
		else
			seg_d = D_W'(cfg_regs.sub) + (idx_q ? D_W'(cfg_regs.sub) : '0) - D_W'(cursor_q);
	end

	assign seg_inf  = seg_d[D_W-1];
	assign seg_zero = (seg_d == '0);
	assign seg_fit  = !seg_inf && (seg_d <= D_W'(left_q));
	assign seg_brk  = (left_q == '0) || (!cfg_regs.static_mode && local_q[idx_q]);

	assign cursor_nxt = ((cur_ext + EXT_W'(1)) >= size_ext) ? '0 : cursor_q + CUR_W'(1);
	assign addr_nxt   = (addr_q == ADDR_W'(STORE_FRAMES - 1)) ? '0 : addr_q + ADDR_W'(1);

	assign is_last = (emitted_q + CNT_W'(1)) == n_q;

	assign half_end = (state_q == S_SEG && !seg_brk && seg_zero) ||
		(state_q == S_FRAME && can_issue && !inf_q && avail_q == SIZE_W'(1));
	assign more_sil = (state_q == S_SEG) || (left_q != CNT_W'(1));

	// write address reduced modulo the store depth, one shifted divisor a cycle
	assign wmod_div = 32'(STORE_FRAMES) << step_q;
	assign wa_red   = (32'(wa_q) >= wmod_div) ? wa_q - WA_W'(wmod_div) : wa_q;

	always_comb begin
		issue_valid   = 1'b0;
		issue.kind    = ppabr_pkg::KIND_ACK;
		issue.count   = '0;
		issue.playing = play_out_q;
		issue.last    = is_last;
		case (state_q)
			S_FRAME: begin
				issue_valid = 1'b1;
				issue.kind  = ppabr_pkg::KIND_STORED;
				if (is_last)
					issue.count = cfg_regs.static_mode ? got_q + CNT_W'(1) : n_q;
			end
			S_SIL: begin
				issue_valid = 1'b1;
				issue.kind  = ppabr_pkg::KIND_SILENCE;
				if (is_last)
					issue.count = cfg_regs.static_mode ? got_q : n_q;
			end
			S_ACK: begin
				issue_valid   = 1'b1;
				issue.playing = now_play;
				issue.last    = 1'b1;
			end
			default: ;
		endcase
	end

	assign mem_re    = (state_q == S_FRAME) && can_issue;
	assign mem_raddr = addr_q;

	always_comb begin
		if (state_q == S_WMOD) begin
			mem_we    = (step_q == '0);
			mem_waddr = ADDR_W'(wa_red);
			mem_wdata = wframe_q;
		end else begin
			mem_we    = !WMOD_NEED && accept &&
				(ppabr_pkg::op_t'(items.operation) == ppabr_pkg::OP_WRITE);
			mem_waddr = ADDR_W'(items.write_address);
			mem_wdata = FRAME_BITS'(items.write_frame);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cursor_q   <= '0;
			consumed_q <= 2'b11;
			playing_q  <= 1'b0;
			paused_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_ACK;
						unique case (ppabr_pkg::op_t'(items.operation))
							ppabr_pkg::OP_READ: begin
								n_q        <= n_sat;
								left_q     <= n_sat;
								got_q      <= '0;
								emitted_q  <= '0;
								idx_q      <= cursor_idx;
								local_q    <= consumed_q;
								play_out_q <= now_play;
								if (n_sat == '0 || (cfg_regs.size != '0 && cursor_hi))
									state_q <= S_ACK;
								else if (cfg_regs.size == '0)
									state_q <= S_SIL;
								else
									state_q <= S_SEG;
							end
							ppabr_pkg::OP_WRITE: begin
								wa_q     <= items.write_address;
								step_q   <= STEP_W'(WMOD_TOP);
								wframe_q <= FRAME_BITS'(items.write_frame);
								if (WMOD_NEED)
									state_q <= S_WMOD;
							end
							ppabr_pkg::OP_FILL: consumed_q[items.half_select] <= 1'b0;
							ppabr_pkg::OP_PLAY: begin
								playing_q <= 1'b1;
								paused_q  <= 1'b0;
								cursor_q  <= '0;
							end
							ppabr_pkg::OP_STOP: begin
								if (now_play) begin
									playing_q  <= 1'b0;
									paused_q   <= 1'b0;
									cursor_q   <= '0;
									consumed_q <= 2'b11;
								end
							end
							ppabr_pkg::OP_PAUSE:  paused_q <= 1'b1;
							ppabr_pkg::OP_RESUME: paused_q <= 1'b0;
							default: ;
						endcase
					end
				end
				S_WMOD: begin
					wa_q <= wa_red;
					if (step_q == '0)
						state_q <= S_ACK;
					else
						step_q <= step_q - STEP_W'(1);
				end
				S_SEG: begin
					if (seg_brk) begin
						state_q <= (emitted_q == n_q) ? S_IDLE : S_SIL;
					end else begin
						if (!cfg_regs.loop_enable && seg_fit)
							play_out_q <= 1'b0;
						if (seg_zero) begin
							if (cur_ext >= size_ext)
								cursor_q <= '0;
						end else begin
							avail_q <= seg_d[SIZE_W-1:0];
							inf_q   <= seg_inf;
							addr_q  <= ADDR_W'(cursor_q);
							state_q <= S_FRAME;
						end
					end
				end
				S_FRAME: begin
					if (can_issue) begin
						emitted_q <= emitted_q + CNT_W'(1);
						got_q     <= got_q + CNT_W'(1);
						left_q    <= left_q - CNT_W'(1);
						addr_q    <= addr_nxt;
						cursor_q  <= cursor_nxt;
						avail_q   <= avail_q - SIZE_W'(1);
						if (left_q == CNT_W'(1))
							state_q <= S_IDLE;
					end
				end
				S_SIL: begin
					if (can_issue) begin
						emitted_q <= emitted_q + CNT_W'(1);
						if (is_last)
							state_q <= S_IDLE;
					end
				end
				S_ACK: begin
					if (can_issue)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase

			// end of a half: mark it, flip halves, stop unless looping
			if (half_end) begin
				consumed_q[idx_q] <= 1'b1;
				local_q[idx_q]    <= 1'b1;
				idx_q             <= !idx_q;
				if (!cfg_regs.loop_enable) begin
					if (now_play) begin
						playing_q  <= 1'b0;
						paused_q   <= 1'b0;
						cursor_q   <= '0;
						consumed_q <= 2'b11;
					end
					state_q <= more_sil ? S_SIL : S_IDLE;
				end else begin
					state_q <= S_SEG;
				end
			end
		end
	end

	a_got_left: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FRAME |->
			({1'b0, got_q} + {1'b0, left_q}) == {1'b0, n_q})
		else $error("stored and pending frame counts disagree with request");

	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FRAME || state_q == S_SIL) |-> emitted_q < n_q)
		else $error("more results issued than requested");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FRAME |-> (cur_ext < size_ext || cfg_regs.size == SIZE_W'(1)))
		else $error("cursor walked past the buffer");

	a_play_rewind: assert property (@(posedge clk) disable iff (!arst_n)
		accept && ppabr_pkg::op_t'(items.operation) == ppabr_pkg::OP_PLAY |=>
			cursor_q == '0 && state_q == S_ACK && playing_q)
		else $error("play did not rewind the cursor");

endmodule

[rtl/core/ping_pong_audio_buffer_reader.sv]
`timescale 1ns / 1ps
// event and write items: one acknowledgement result, issued from S_ACK (writes first step
// through the address reduction of S_WMOD when the store depth is below 4096); the next
// item is accepted once the acknowledgement is issued. read of n frames: stored frames come
// from the single read port of the frame memory, one per cycle within a segment while results are taken
// reset rewinds the cursor, marks both halves drained, stops play and restores the default
// configuration at once; frame store contents stay undefined until written and get no clearing pass
module ping_pong_audio_buffer_reader #(
	parameter int STORE_FRAMES = ppabr_pkg::STORE_FRAMES_DEF,
	parameter int FRAME_BITS   = ppabr_pkg::FRAME_BITS_DEF,
	parameter int MAX_REQUEST  = ppabr_pkg::MAX_REQUEST_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	ppabr_item_if.sink     items,
	ppabr_result_if.source results,
	ppabr_cfg_if.sink      cfg
);

	localparam int ADDR_W   = $clog2(STORE_FRAMES);
	localparam int SIZE_W   = ppabr_pkg::SIZE_W;
	localparam int RST_SIZE = (STORE_FRAMES < ppabr_pkg::SIZE_RESET) ?
		STORE_FRAMES : ppabr_pkg::SIZE_RESET;
	localparam int RST_SUB  = RST_SIZE / 2;

	ppabr_pkg::cfg_t        cfg_q;
	logic [SIZE_W-1:0]      size_sat;
	logic [SIZE_W-1:0]      sub_val;

	ppabr_pkg::issue_t      issue;
	logic                   issue_valid;
	logic                   can_issue;
	logic                   mem_we;
	logic [ADDR_W-1:0]      mem_waddr;
	logic [FRAME_BITS-1:0]  mem_wdata;
	logic                   mem_re;
	logic [ADDR_W-1:0]      mem_raddr;
	logic [FRAME_BITS-1:0]  mem_rdata;

	assign cfg.ready = 1'b1;

	assign size_sat = (32'(cfg.wdata) > 32'(STORE_FRAMES)) ? SIZE_W'(STORE_FRAMES) : cfg.wdata;
	assign sub_val  = (size_sat > SIZE_W'(1)) ? (size_sat >> 1) : size_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.static_mode <= 1'b1;
			cfg_q.loop_enable <= 1'b0;
			cfg_q.size        <= SIZE_W'(RST_SIZE);
			cfg_q.sub         <= SIZE_W'(RST_SUB);
		end else if (cfg.valid) begin
			unique case (ppabr_pkg::cfg_idx_t'(cfg.addr))
				ppabr_pkg::CFG_STATIC_MODE: cfg_q.static_mode <= cfg.wdata[0];
				ppabr_pkg::CFG_LOOP_ENABLE: cfg_q.loop_enable <= cfg.wdata[0];
				ppabr_pkg::CFG_BUFFER_FRAMES: begin
					cfg_q.size <= size_sat;
					cfg_q.sub  <= sub_val;
				end
				default: ;
			endcase
		end
	end

	ppabr_read_seq #(
		.STORE_FRAMES (STORE_FRAMES),
		.FRAME_BITS   (FRAME_BITS),
		.MAX_REQUEST  (MAX_REQUEST)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.items       (items),
		.cfg_regs    (cfg_q),
		.can_issue   (can_issue),
		.issue_valid (issue_valid),
		.issue       (issue),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_re      (mem_re),
		.mem_raddr   (mem_raddr)
	);

	ppabr_frame_mem #(
		.DEPTH (STORE_FRAMES),
		.WIDTH (FRAME_BITS)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	ppabr_out_stage #(
		.FRAME_BITS (FRAME_BITS)
	) u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.issue_valid (issue_valid),
		.issue       (issue),
		.can_issue   (can_issue),
		.rd_data     (mem_rdata),
		.results     (results)
	);

endmodule

[test/ping_pong_audio_buffer_reader_tb.sv]
`timescale 1ns / 1ps

module ping_pong_audio_buffer_reader_tb;
	import ppabr_pkg::*;

	localparam int unsigned STORE       = STORE_FRAMES_DEF;
	localparam int unsigned MAX_REQ     = MAX_REQUEST_DEF;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [CNT_W-1:0]   req;
		logic [WA_W-1:0]    addr;
		logic [FRAME_W-1:0] data;
		logic               half;
	} player_cmd_t;

	typedef struct packed {
		logic [FRAME_W-1:0] frame;
		kind_t              kind;
		logic [CNT_W-1:0]   count;
		logic               playing;
		logic               last;
	} frame_result_t;

	logic clk;
	logic arst_n;

	ppabr_item_if   items_if ();
	ppabr_result_if results_if ();
	ppabr_cfg_if    cfg_if ();

	ping_pong_audio_buffer_reader uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items_if),
		.results (results_if),
		.cfg     (cfg_if)
	);

	// playback model state
	logic [FRAME_W-1:0] store_mem [STORE];
	bit                 store_known [STORE];
	int unsigned        cursor_pos;
	bit                 half_drained [2];
	bit                 play_on;
	bit                 pause_on;
	bit                 cfg_static;
	bit                 cfg_loop;
	int unsigned        cfg_frames;

	frame_result_t frames_due [$];
	int unsigned   touched_addrs [$];

	int unsigned idle_pct = 31;
	bit          hold_request = 0;
	int unsigned err_count = 0;
	int unsigned items_sent = 0;
	int unsigned reads_sent = 0;
	int unsigned results_seen = 0;
	int unsigned reg_writes = 0;
	int unsigned cycle_count = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic void push_frame(logic [FRAME_W-1:0] v, kind_t k, int unsigned c, bit last);
		frame_result_t r;
		r.frame   = v;
		r.kind    = k;
		r.count   = c[CNT_W-1:0];
		r.playing = play_on && !pause_on;
		r.last    = last;
		frames_due.push_back(r);
	endfunction

	function automatic void halt_playback();
		if (play_on && !pause_on) begin
			play_on         = 1'b0;
			pause_on        = 1'b0;
			cursor_pos      = 0;
			half_drained[0] = 1'b1;
			half_drained[1] = 1'b1;
		end
	endfunction

	// with emit low only the store addresses touched are recorded
	function automatic void predict_read_frames(int unsigned n_req, bit emit);
		int unsigned n, buf_len, half_len, idx, got, cnt, left, avail, take, it, i;
		logic [FRAME_W-1:0] vals [MAX_REQ];
		bit seen_end [2];
		n = n_req > MAX_REQ ? MAX_REQ : n_req;
		got = 0;
		touched_addrs.delete();
		if (n == 0) begin
			if (emit)
				push_frame('0, KIND_ACK, 0, 1'b1);
			return;
		end
		buf_len = cfg_frames > STORE ? STORE : cfg_frames;
		if (buf_len != 0) begin
			half_len = buf_len > 1 ? buf_len / 2 : buf_len;
			idx = cursor_pos / half_len;
			if (idx > 1) begin
				if (emit)
					push_frame('0, KIND_ACK, 0, 1'b1);
				return;
			end
			seen_end[0] = half_drained[0];
			seen_end[1] = half_drained[1];
			for (it = 0; it < 4 * MAX_REQ + 8; it++) begin
				if (cfg_static) begin
					if (got >= n)
						break;
				end else if (seen_end[idx & 1]) begin
					break;
				end
				left = n - got;
				if (left == 0)
					break;
				// unsigned wrap when the cursor sits past a shrunken buffer
				if (cfg_static)
					avail = buf_len - cursor_pos;
				else
					avail = half_len - (cursor_pos - half_len * idx);
				take = left > avail ? avail : left;
				for (i = 0; i < take; i++) begin
					touched_addrs.push_back((cursor_pos + i) % STORE);
					vals[got + i] = store_mem[(cursor_pos + i) % STORE];
				end
				cursor_pos = (cursor_pos + take) % buf_len;
				got += take;
				if (take == avail) begin
					half_drained[idx & 1] = 1'b1;
					seen_end[idx & 1]     = 1'b1;
					idx = (idx + 1) % 2;
					if (!cfg_loop) begin
						halt_playback();
						break;
					end
				end
			end
		end
		if (!emit)
			return;
		cnt = cfg_static ? got : n;
		for (i = 0; i < n; i++) begin
			if (i < got)
				push_frame(vals[i], KIND_STORED, (i + 1 == n) ? cnt : 0, i + 1 == n);
			else
				push_frame('0, KIND_SILENCE, (i + 1 == n) ? cnt : 0, i + 1 == n);
		end
	endfunction

	function automatic void predict_cmd(player_cmd_t cmd);
		if (cmd.op == OP_READ) begin
			predict_read_frames(cmd.req, 1'b1);
			return;
		end
		case (cmd.op)
			OP_WRITE: begin
				store_mem[cmd.addr]   = cmd.data;
				store_known[cmd.addr] = 1'b1;
			end
			OP_FILL: half_drained[cmd.half] = 1'b0;
			OP_PLAY: begin
				play_on    = 1'b1;
				pause_on   = 1'b0;
				cursor_pos = 0;
			end
			OP_STOP: halt_playback();
			OP_PAUSE: pause_on = 1'b1;
			OP_RESUME: pause_on = 1'b0;
			default: ;
		endcase
		push_frame('0, KIND_ACK, 0, 1'b1);
	endfunction

	function automatic player_cmd_t cmd_of(logic [OP_W-1:0] op);
		player_cmd_t cmd;
		cmd.op   = op;
		cmd.req  = $urandom_range(MAX_REQ, 1);
		cmd.addr = $urandom;
		cmd.data = $urandom;
		cmd.half = $urandom_range(1);
		return cmd;
	endfunction

	task automatic offer_item(player_cmd_t cmd);
		while ($urandom_range(99) < idle_pct) begin
			items_if.valid <= 1'b0;
			@(posedge clk);
		end
		items_if.operation      <= cmd.op;
		items_if.request_frames <= cmd.req;
		items_if.write_address  <= cmd.addr;
		items_if.write_frame    <= cmd.data;
		items_if.half_select    <= cmd.half;
		items_if.valid          <= 1'b1;
		predict_cmd(cmd);
		items_sent++;
		if (cmd.op == OP_READ)
			reads_sent++;
		do @(posedge clk); while (items_if.ready !== 1'b1);
	endtask

	// fill every store entry the read will reach so no unwritten frame is read
	task automatic prime_read(int unsigned n);
		int unsigned save_cursor;
		bit save_drained0, save_drained1, save_play, save_pause;
		int unsigned addrs [$];
		player_cmd_t w;
		save_cursor   = cursor_pos;
		save_drained0 = half_drained[0];
		save_drained1 = half_drained[1];
		save_play     = play_on;
		save_pause    = pause_on;
		predict_read_frames(n, 1'b0);
		addrs           = touched_addrs;
		cursor_pos      = save_cursor;
		half_drained[0] = save_drained0;
		half_drained[1] = save_drained1;
		play_on         = save_play;
		pause_on        = save_pause;
		foreach (addrs[i]) begin
			if (!store_known[addrs[i]]) begin
				w = cmd_of(OP_WRITE);
				w.addr = addrs[i];
				offer_item(w);
			end
		end
	endtask

	task automatic do_item(player_cmd_t cmd);
		if (cmd.op == OP_READ)
			prime_read(cmd.req);
		offer_item(cmd);
	endtask

	task automatic do_op(logic [OP_W-1:0] op);
		do_item(cmd_of(op));
	endtask

	task automatic do_read(int unsigned n);
		player_cmd_t cmd;
		cmd = cmd_of(OP_READ);
		cmd.req = n;
		do_item(cmd);
	endtask

	task automatic do_fill(bit half);
		player_cmd_t cmd;
		cmd = cmd_of(OP_FILL);
		cmd.half = half;
		do_item(cmd);
	endtask

	task automatic drain_results();
		items_if.valid <= 1'b0;
		while (frames_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_register(cfg_idx_t idx, logic [SIZE_W-1:0] value);
		@(posedge clk);
		cfg_if.addr  <= idx;
		cfg_if.wdata <= value;
		cfg_if.valid <= 1'b1;
		do @(posedge clk); while (cfg_if.ready !== 1'b1);
		cfg_if.valid <= 1'b0;
		case (idx)
			CFG_STATIC_MODE: cfg_static = value[0];
			CFG_LOOP_ENABLE: cfg_loop = value[0];
			CFG_BUFFER_FRAMES: cfg_frames = value;
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic set_config(bit st, bit lp, int unsigned frames);
		drain_results();
		write_register(CFG_STATIC_MODE, st);
		write_register(CFG_LOOP_ENABLE, lp);
		write_register(CFG_BUFFER_FRAMES, frames);
	endtask

	task automatic test_event_ops();
		player_cmd_t cmd;
		do_op(OP_STOP);
		do_op(OP_PLAY);
		do_op(OP_PAUSE);
		// stop while paused leaves the play state alone
		do_op(OP_STOP);
		do_op(OP_RESUME);
		do_op(OP_UNUSED);
		do_fill(1'b0);
		do_fill(1'b1);
		cmd = cmd_of(OP_WRITE);
		cmd.addr = '1;
		cmd.data = '1;
		do_item(cmd);
		cmd.addr = '0;
		cmd.data = '0;
		do_item(cmd);
	endtask

	task automatic test_static_reads();
		do_read(0);
		do_read(1);
		do_read(127);
	endtask

	task automatic test_stream_halves();
		set_config(1'b0, 1'b0, 8);
		do_op(OP_PLAY);
		do_fill(1'b0);
		do_fill(1'b1);
		// half end without looping stops, rest is silence
		do_read(5);
		do_read(3);
		drain_results();
		write_register(CFG_LOOP_ENABLE, 1'b1);
		do_op(OP_PLAY);
		do_fill(1'b0);
		do_fill(1'b1);
		do_read(64);
	endtask

	task automatic test_size_corners();
		set_config(1'b1, 1'b0, 0);
		do_read(10);
		drain_results();
		write_register(CFG_STATIC_MODE, 1'b0);
		do_read(10);
		set_config(1'b1, 1'b1, 8191);
		do_read(4);
		set_config(1'b1, 1'b1, 7);
		do_op(OP_PLAY);
		do_read(6);
		// odd size leaves the cursor past the second half
		set_config(1'b0, 1'b1, 7);
		do_read(5);
		set_config(1'b1, 1'b1, 1);
		do_read(3);
	endtask

	task automatic test_backpressure();
		set_config(1'b1, 1'b1, 64);
		do_read(64);
		hold_request = 1'b1;
		idle_pct = 0;
		repeat (6) do_read(64);
		drain_results();
		idle_pct = 31;
	endtask

	task automatic run_mix_phase(bit st, bit lp, int unsigned frames, int unsigned n_items);
		player_cmd_t cmd;
		int unsigned r, span;
		set_config(st, lp, frames);
		span = frames > STORE ? STORE : frames;
		if (!st) begin
			do_op(OP_PLAY);
			do_fill(1'b0);
			do_fill(1'b1);
		end
		repeat (n_items) begin
			r = $urandom_range(99);
			if (r < 45) begin
				cmd = cmd_of(OP_READ);
				r = $urandom_range(99);
				if (r < 5)
					cmd.req = 0;
				else if (r < 12)
					cmd.req = $urandom_range(127, MAX_REQ + 1);
			end else if (r < 63) begin
				cmd = cmd_of(OP_WRITE);
				if (span != 0 && $urandom_range(3) != 0)
					cmd.addr = $urandom_range(span - 1);
			end else if (r < 78) begin
				cmd = cmd_of(OP_FILL);
			end else if (r < 85) begin
				cmd = cmd_of(OP_PLAY);
			end else if (r < 89) begin
				cmd = cmd_of(OP_STOP);
			end else if (r < 93) begin
				cmd = cmd_of(OP_PAUSE);
			end else if (r < 97) begin
				cmd = cmd_of(OP_RESUME);
			end else begin
				cmd = cmd_of(OP_UNUSED);
			end
			do_item(cmd);
		end
	endtask

	task automatic test_random_mix();
		run_mix_phase(1'b1, 1'b0, 16, 26);
		run_mix_phase(1'b1, 1'b1, 16, 26);
		run_mix_phase(1'b0, 1'b0, 8, 26);
		run_mix_phase(1'b0, 1'b1, 8, 26);
		run_mix_phase(1'b0, 1'b1, 7, 26);
		run_mix_phase(1'b1, 1'b1, 1, 20);
		run_mix_phase(1'b0, 1'b0, 0, 16);
		run_mix_phase(1'b1, 1'b1, 5, 26);
		run_mix_phase(1'b0, 1'b1, 64, 26);
		// shrinking the buffer strands the cursor beyond it
		run_mix_phase(1'b1, 1'b0, 3, 20);
		idle_pct = 0;
		run_mix_phase(1'b0, 1'b1, 16, 40);
		idle_pct = 31;
		run_mix_phase(1'b1, 1'b0, 4096, 16);
		run_mix_phase(1'b0, 1'b1, 8191, 16);
		run_mix_phase(1'b1, 1'b1, 33, 26);
	endtask

	// receiver side, with an optional long hold-off
	initial begin
		results_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				results_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				results_if.ready <= ($urandom_range(99) >= idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		frame_result_t want;
		if (arst_n && results_if.valid === 1'b1 && results_if.ready === 1'b1) begin
			results_seen++;
			if (frames_due.size() == 0) begin
				$error("result with nothing expected: frame_value %h result_kind %0d",
					results_if.frame_value, results_if.result_kind);
				err_count++;
			end else begin
				want = frames_due.pop_front();
				if (results_if.frame_value !== want.frame) begin
					$error("frame_value expected %h actual %h", want.frame, results_if.frame_value);
					err_count++;
				end
				if (results_if.result_kind !== want.kind) begin
					$error("result_kind expected %0d actual %0d", want.kind, results_if.result_kind);
					err_count++;
				end
				if (results_if.frames_counted !== want.count) begin
					$error("frames_counted expected %0d actual %0d", want.count,
						results_if.frames_counted);
					err_count++;
				end
				if (results_if.is_playing !== want.playing) begin
					$error("is_playing expected %0d actual %0d", want.playing, results_if.is_playing);
					err_count++;
				end
				if (results_if.last_result !== want.last) begin
					$error("last_result expected %0d actual %0d", want.last, results_if.last_result);
					err_count++;
				end
			end
		end
	end

	initial begin
		arst_n                  <= 1'b0;
		items_if.valid          <= 1'b0;
		items_if.operation      <= '0;
		items_if.request_frames <= '0;
		items_if.write_address  <= '0;
		items_if.write_frame    <= '0;
		items_if.half_select    <= 1'b0;
		cfg_if.valid            <= 1'b0;
		cfg_if.addr             <= CFG_STATIC_MODE;
		cfg_if.wdata            <= '0;
		cursor_pos      = 0;
		half_drained[0] = 1'b1;
		half_drained[1] = 1'b1;
		play_on         = 1'b0;
		pause_on        = 1'b0;
		cfg_static      = 1'b1;
		cfg_loop        = 1'b0;
		cfg_frames      = SIZE_RESET;
		foreach (store_known[i])
			store_known[i] = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_event_ops();
		test_static_reads();
		test_stream_halves();
		test_size_corners();
		test_backpressure();
		test_random_mix();
		drain_results();

		if (frames_due.size() != 0) begin
			$error("%0d expected results never arrived", frames_due.size());
			err_count++;
		end
		$display("Covered %0d items (%0d reads) and %0d results over %0d register writes,",
			items_sent, reads_sent, results_seen, reg_writes);
		$display("static and streamed, looped or not, empty to oversized buffers, with a long stall");
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
